[design/ppid_pkg.sv]
package ppid_pkg;

  // Field widths
  localparam int POS_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int BAND_W    = 16;
  localparam int ERR_W     = POS_W + 1;
  localparam int DERR_W    = ERR_W + 1;
  localparam int DRIVE_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Arithmetic constants
  localparam int FRAC_BITS  = 8;
  localparam int ROUND_HALF = 128;
  localparam int DECAY_NUM  = 230;
  localparam int DRIVE_MAX  = 16384;

  // Register reset values
  localparam int PROP_GAIN_RST    = 256;
  localparam int ERROR_BAND_RST   = 50;
  localparam int WINDUP_LIMIT_RST = 60;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_ERROR_BAND   = 3'd3,
    REG_WINDUP_LIMIT = 3'd4
  } cfg_reg_t;

  // Datapath operations, one per controller step
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_PROP,
    OP_DERIV,
    OP_ITEST,
    OP_DECAY,
    OP_IMUL,
    OP_SUM,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic windup;
    logic out_busy;
  } dp_stat_t;

endpackage

[design/ppid_in_if.sv]
interface ppid_in_if;
  import ppid_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] measured_position;
  logic signed [POS_W-1:0] target_position;

  modport source(output valid, output measured_position, output target_position,
                 input ready);
  modport sink(input valid, input measured_position, input target_position,
               output ready);
endinterface

[design/ppid_out_if.sv]
interface ppid_out_if;
  import ppid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_value;
  logic                      saturated;

  modport source(output valid, output drive_value, output saturated, input ready);
  modport sink(input valid, input drive_value, input saturated, output ready);
endinterface

[design/ppid_cfg_if.sv]
interface ppid_cfg_if;
  import ppid_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[design/ppid_ctrl.sv]
module ppid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  ppid_pkg::dp_stat_t stat,
  output ppid_pkg::dp_cmd_t  cmd
);
  import ppid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROP,
    S_DERIV,
    S_ITEST,
    S_DECAY,
    S_IMUL,
    S_SUM,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Step sequence; the decay branch recomputes the integral product
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (stat.in_valid) state_next = S_PROP;
      S_PROP:  state_next = S_DERIV;
      S_DERIV: state_next = S_ITEST;
      S_ITEST: state_next = S_DECAY;
      S_DECAY: state_next = stat.windup ? S_IMUL : S_OUT;
      S_IMUL:  state_next = S_SUM;
      S_SUM:   state_next = S_OUT;
      S_OUT:   if (!stat.out_busy) state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command decode
  always_comb begin
    unique case (state)
      S_IDLE:  cmd.op = OP_IDLE;
      S_PROP:  cmd.op = OP_PROP;
      S_DERIV: cmd.op = OP_DERIV;
      S_ITEST: cmd.op = OP_ITEST;
      S_DECAY: cmd.op = OP_DECAY;
      S_IMUL:  cmd.op = OP_IMUL;
      S_SUM:   cmd.op = OP_SUM;
      S_OUT:   cmd.op = OP_OUT;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && stat.in_valid) |=> (state == S_PROP))
    else $error("accepted beat did not start the sequence");

  a_no_decay_skips: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECAY && !stat.windup) |=> (state == S_OUT))
    else $error("no-decay path did not go straight to output");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && stat.out_busy) |=> (state == S_OUT))
    else $error("left output step while result register was full");

endmodule

[design/ppid_dp.sv]
module ppid_dp #(
  parameter int INTEGRAL_WIDTH = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  ppid_pkg::dp_cmd_t  cmd,
  output ppid_pkg::dp_stat_t stat,
  ppid_in_if.sink            sample,
  ppid_out_if.source         result,
  ppid_cfg_if.sink           cfg
);
  import ppid_pkg::*;

  localparam int IW     = INTEGRAL_WIDTH;
  localparam int MB_W   = (IW > DERR_W) ? IW : DERR_W;
  localparam int PROD_W = GAIN_W + MB_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [IW-1:0]    I_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0]    I_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(DRIVE_MAX);
  localparam logic signed [ACC_W-1:0] Q_MIN = -ACC_W'(DRIVE_MAX);

  // Configuration registers
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;
  logic signed [GAIN_W-1:0] deriv_gain;
  logic [BAND_W-1:0]        error_band;
  logic [BAND_W-1:0]        windup_limit;

  // Controller state and working registers
  logic signed [ERR_W-1:0]  previous_error;
  logic signed [IW-1:0]     error_integral;
  logic signed [ERR_W-1:0]  err;
  logic signed [DERR_W-1:0] derr;
  logic                     integ_en;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic accept;
  logic out_load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= GAIN_W'(PROP_GAIN_RST);
      integ_gain   <= '0;
      deriv_gain   <= '0;
      error_band   <= BAND_W'(ERROR_BAND_RST);
      windup_limit <= BAND_W'(WINDUP_LIMIT_RST);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PROP_GAIN:    prop_gain    <= cfg.data;
        REG_INTEG_GAIN:   integ_gain   <= cfg.data;
        REG_DERIV_GAIN:   deriv_gain   <= cfg.data;
        REG_ERROR_BAND:   error_band   <= cfg.data;
        REG_WINDUP_LIMIT: windup_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input beat: error, error change and integration enable
  logic signed [ERR_W-1:0]  err_in;
  logic signed [DERR_W-1:0] derr_in;
  logic [ERR_W-1:0]         err_mag;
  logic [DERR_W-1:0]        derr_mag;

  assign sample.ready = (cmd.op == OP_IDLE);
  assign accept       = sample.valid && sample.ready;

  assign err_in   = ERR_W'(sample.target_position) - ERR_W'(sample.measured_position);
  assign derr_in  = DERR_W'(err_in) - DERR_W'(previous_error);
  assign err_mag  = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);
  assign derr_mag = derr_in[DERR_W-1] ? DERR_W'(-derr_in) : DERR_W'(derr_in);

  // Shared multiplier
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    unique case (cmd.op)
      OP_PROP: begin
        mul_a = prop_gain;
        mul_b = MB_W'(err);
      end
      OP_DERIV: begin
        mul_a = deriv_gain;
        mul_b = MB_W'(derr);
      end
      default: begin
        mul_a = integ_gain;
        mul_b = MB_W'(error_integral);
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Saturating integral update
  logic signed [IW:0]   isum;
  logic signed [IW-1:0] integ_sat;

  assign isum      = (IW+1)'(error_integral) + (IW+1)'(err);
  assign integ_sat = (isum[IW] != isum[IW-1]) ? (isum[IW] ? I_MIN : I_MAX)
                                              : IW'(isum);

  // Windup test and decay by 230/256, truncated toward zero
  logic [PROD_W-1:0]    prod_mag;
  logic [IW-1:0]        int_mag;
  logic [IW+7:0]        decay_prod;
  logic [IW-1:0]        decay_mag;
  logic signed [IW-1:0] integ_decay;

  assign prod_mag    = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign stat.windup = (prod_mag >= PROD_W'({windup_limit, {FRAC_BITS{1'b0}}}));
  assign int_mag     = error_integral[IW-1] ? IW'(-error_integral) : IW'(error_integral);
  assign decay_prod  = (IW+8)'(int_mag) * (IW+8)'(DECAY_NUM);
  assign decay_mag   = decay_prod[IW+7:FRAC_BITS];
  assign integ_decay = error_integral[IW-1] ? -$signed(decay_mag) : $signed(decay_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_integral <= '0;
    end else begin
      if (accept) begin
        previous_error <= err_in;
      end
      if (cmd.op == OP_PROP && integ_en) begin
        error_integral <= integ_sat;
      end else if (cmd.op == OP_DECAY && stat.windup) begin
        error_integral <= integ_decay;
      end
    end
  end

  // Working registers and accumulator
  always_ff @(posedge clk) begin
    if (accept) begin
      err      <= err_in;
      derr     <= derr_in;
      integ_en <= (err_mag <= ERR_W'(error_band)) && (derr_mag <= DERR_W'(error_band));
    end
    unique case (cmd.op)
      OP_PROP: prod <= mul_p;
      OP_DERIV: begin
        acc  <= ACC_W'(prod);
        prod <= mul_p;
      end
      OP_ITEST: begin
        acc  <= acc + ACC_W'(prod);
        prod <= mul_p;
      end
      OP_DECAY: if (!stat.windup) acc <= acc + ACC_W'(prod);
      OP_IMUL: prod <= mul_p;
      OP_SUM:  acc <= acc + ACC_W'(prod);
      default: ;
    endcase
  end

  // Round half up, saturate, result register
  logic signed [ACC_W-1:0]   rsum;
  logic signed [ACC_W-1:0]   q;
  logic signed [DRIVE_W-1:0] drive_next;
  logic                      sat_next;

  assign rsum = acc + ACC_W'(ROUND_HALF);
  assign q    = rsum >>> FRAC_BITS;

  always_comb begin
    priority if (q > Q_MAX) begin
      drive_next = DRIVE_W'(DRIVE_MAX);
      sat_next   = 1'b1;
    end else if (q < Q_MIN) begin
      drive_next = -DRIVE_W'(DRIVE_MAX);
      sat_next   = 1'b1;
    end else begin
      drive_next = DRIVE_W'(q);
      sat_next   = 1'b0;
    end
  end

  assign stat.out_busy = result.valid && !result.ready;
  assign stat.in_valid = sample.valid;
  assign out_load      = (cmd.op == OP_OUT) && !stat.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.drive_value <= drive_next;
      result.saturated   <= sat_next;
    end
  end

  a_drive_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.drive_value <= DRIVE_W'(DRIVE_MAX) &&
                      result.drive_value >= -DRIVE_W'(DRIVE_MAX)))
    else $error("drive value outside limit");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturated) |->
      (result.drive_value == DRIVE_W'(DRIVE_MAX) ||
       result.drive_value == -DRIVE_W'(DRIVE_MAX)))
    else $error("saturated flag without clipped drive");

  a_decay_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DECAY && stat.windup) |=> (int_mag <= $past(int_mag)))
    else $error("integral decay grew the integral");

endmodule

[design/position_pid_with_windup_guard_top.sv]
// Position PID controller with conditional-integration anti-windup. Each
// sample beat carries a measured and a target position; each result beat
// carries the Q8.8-rounded, saturated drive value and a clip flag. The result
// register is loaded at the output step after the proportional, derivative,
// integral-test and decay steps, and after integral multiply and sum steps
// when the integral decays, because the three gain products and the windup
// test all share one 16-bit by max(INTEGRAL_WIDTH, 18)-bit multiplier in turn.
// The sequence then returns to idle, the only step that takes a sample, so no
// new sample is taken before the last is through. It holds at the output
// step while the previous result is still waiting to be taken, and that stall
// adds directly to the item time. A new sample is taken as soon as the
// sequence returns to idle, even while the last result waits to be taken.
// Configuration writes are accepted every cycle and should be made only while the block is idle.
module position_pid_with_windup_guard_top #(
  parameter int INTEGRAL_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst,
  ppid_in_if.sink    sample,
  ppid_out_if.source result,
  ppid_cfg_if.sink   cfg
);
  import ppid_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ppid_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  ppid_dp #(
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

endmodule

[verif/tb_top.sv]
module tb_top;
  import ppid_pkg::*;

  localparam int INTEG_W        = 24;
  localparam int STALL_MAX      = 3;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 80;

  localparam longint POS_MAX  = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN  = -POS_MAX - 1;
  localparam longint GAIN_MAX = (longint'(1) <<< (GAIN_W - 1)) - 1;
  localparam longint GAIN_MIN = -GAIN_MAX - 1;
  localparam longint LIM_MAX  = (longint'(1) <<< BAND_W) - 1;
  localparam longint ERR_MAX  = POS_MAX - POS_MIN;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clip;
  } drive_result_t;

  logic clk;
  logic rst;

  ppid_in_if  smp_bus();
  ppid_out_if res_bus();
  ppid_cfg_if cfg_bus();

  position_pid_with_windup_guard_top #(.INTEGRAL_WIDTH(INTEG_W)) dut (
    .clk(clk),
    .rst(rst),
    .sample(smp_bus),
    .result(res_bus),
    .cfg(cfg_bus)
  );

  // Mirror of the controller registers and state
  logic signed [GAIN_W-1:0]  kp;
  logic signed [GAIN_W-1:0]  ki;
  logic signed [GAIN_W-1:0]  kd;
  logic [BAND_W-1:0]         err_band;
  logic [BAND_W-1:0]         windup_lim;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [INTEG_W-1:0] integ;

  drive_result_t expected_drive_q[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  bit            gaps_on;
  int            hold_request;
  longint        walk_err;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint abs_val(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // One controller step: updates the mirrored state, returns the drive beat
  function automatic drive_result_t pid_predict(input logic signed [POS_W-1:0] meas,
                                                input logic signed [POS_W-1:0] targ);
    longint imax, imin, e, d, n, mag_i, acc, q;
    drive_result_t r;
    imax = (longint'(1) <<< (INTEG_W - 1)) - 1;
    imin = -imax - 1;
    e = longint'(targ) - longint'(meas);
    d = e - longint'(last_err);
    n = longint'(integ);
    // conditional integration, saturating
    if (abs_val(d) <= longint'(err_band) && abs_val(e) <= longint'(err_band)) begin
      n = n + e;
      if (n > imax) n = imax;
      if (n < imin) n = imin;
    end
    // windup guard: scale by 230/256, truncating toward zero
    if (abs_val(longint'(ki) * n) >= (longint'(windup_lim) <<< FRAC_BITS)) begin
      mag_i = (abs_val(n) * DECAY_NUM) >>> FRAC_BITS;
      n = (n < 0) ? -mag_i : mag_i;
    end
    // Q8.8 sum, round half up, clip
    acc = longint'(kp) * e + longint'(ki) * n + longint'(kd) * d + ROUND_HALF;
    q = acc >>> FRAC_BITS;
    r.clip = 1'b0;
    if (q > DRIVE_MAX) begin
      q = DRIVE_MAX;
      r.clip = 1'b1;
    end
    if (q < -DRIVE_MAX) begin
      q = -DRIVE_MAX;
      r.clip = 1'b1;
    end
    r.drive = q[DRIVE_W-1:0];
    integ = n[INTEG_W-1:0];
    last_err = e[ERR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Register writes, tracked as they are accepted
  always @(posedge clk) begin
    if (!rst && cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        REG_PROP_GAIN:    kp = cfg_bus.data;
        REG_INTEG_GAIN:   ki = cfg_bus.data;
        REG_DERIV_GAIN:   kd = cfg_bus.data;
        REG_ERROR_BAND:   err_band = cfg_bus.data;
        REG_WINDUP_LIMIT: windup_lim = cfg_bus.data;
        default: ;
      endcase
    end
  end

  // Predict on every accepted sample beat
  always @(posedge clk) begin
    if (!rst && smp_bus.valid && smp_bus.ready)
      expected_drive_q.push_back(pid_predict(smp_bus.measured_position,
                                             smp_bus.target_position));
  end

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    drive_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_drive_q.size() == 0) begin
        report_mismatch("result beat with no sample pending", res_bus.drive_value, 0);
      end else begin
        want = expected_drive_q.pop_front();
        if (res_bus.drive_value !== want.drive)
          report_mismatch("drive_value", res_bus.drive_value, want.drive);
        if (res_bus.saturated !== want.clip)
          report_mismatch("saturated", res_bus.saturated, want.clip);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no beat for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    res_bus.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
    end
  end

  task automatic send_sample(input longint meas, input longint targ);
    int gap;
    gap = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      smp_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_bus.valid             <= 1'b1;
    smp_bus.measured_position <= meas[POS_W-1:0];
    smp_bus.target_position   <= targ[POS_W-1:0];
    do @(posedge clk); while (!(smp_bus.valid && smp_bus.ready));
  endtask

  // Sample with a given error and a random operating point
  task automatic send_error(input longint err);
    longint meas, targ;
    meas = longint'($urandom_range(0, 65535)) + POS_MIN;
    targ = meas + err;
    if (targ > POS_MAX) begin
      targ = POS_MAX;
      meas = targ - err;
    end
    if (targ < POS_MIN) begin
      targ = POS_MIN;
      meas = targ - err;
    end
    send_sample(meas, targ);
  endtask

  // Error that drifts around the band so integration keeps engaging
  task automatic send_walk();
    longint span, lim;
    lim = longint'(err_band) + 1;
    span = longint'(err_band) / 2 + 1;
    walk_err = walk_err + longint'($urandom_range(0, 2 * span)) - span;
    if (walk_err > lim) walk_err = lim;
    if (walk_err < -lim) walk_err = -lim;
    send_error(walk_err);
  endtask

  task automatic send_noise();
    send_sample(longint'($urandom_range(0, 65535)) + POS_MIN,
                longint'($urandom_range(0, 65535)) + POS_MIN);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value[GAIN_W-1:0];
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gains(input longint p, input longint i, input longint d,
                           input longint band, input longint lim);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_ERROR_BAND, band);
    write_reg(REG_WINDUP_LIMIT, lim);
  endtask

  // Stop offering, let every result come back, then let the block settle
  task automatic wait_for_drain();
    smp_bus.valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic longint rand_gain();
    case ($urandom_range(0, 9))
      0: return GAIN_MIN;
      1: return GAIN_MAX;
      2: return longint'($urandom_range(0, 65535)) + GAIN_MIN;
      default: return longint'($urandom_range(0, 2048)) - 1024;
    endcase
  endfunction

  function automatic longint rand_limit(input int typical_max);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return LIM_MAX;
      2: return longint'($urandom_range(0, 65535));
      default: return longint'($urandom_range(0, typical_max));
    endcase
  endfunction

  // Reset values: unity proportional gain, output limits at the edge
  task automatic test_reset_defaults();
    send_error(0);
    send_error(10);
    send_error(50);
    send_error(-50);
    send_error(51);
    send_error(-300);
    send_error(1000);
    send_error(DRIVE_MAX);
    send_error(DRIVE_MAX + 1);
    send_error(-DRIVE_MAX);
    send_error(-DRIVE_MAX - 1);
    wait_for_drain();
  endtask

  // Extreme gains, limits and positions; rounding of halves
  task automatic test_extremes();
    set_gains(GAIN_MAX, GAIN_MIN, GAIN_MIN, LIM_MAX, LIM_MAX);
    send_sample(POS_MIN, POS_MAX);
    send_sample(POS_MAX, POS_MIN);
    send_sample(0, 0);
    send_sample(POS_MAX, POS_MAX);
    send_sample(POS_MIN, POS_MIN);
    wait_for_drain();
    set_gains(GAIN_MIN, GAIN_MAX, GAIN_MAX, 0, 0);
    send_sample(POS_MIN, POS_MAX);
    send_sample(POS_MAX, POS_MIN);
    send_sample(0, 0);
    send_sample(0, 1);
    send_sample(1, 0);
    wait_for_drain();
    // half gain: odd errors land exactly on halves
    set_gains(128, 0, 0, ERROR_BAND_RST, WINDUP_LIMIT_RST);
    send_error(1);
    send_error(-1);
    send_error(3);
    send_error(-3);
    send_error(2);
    send_error(-2);
    wait_for_drain();
  endtask

  // Writes to indexes past the last register must change nothing
  task automatic test_unknown_index();
    set_gains(300, 20, -40, 80, 500);
    for (int k = int'(REG_WINDUP_LIMIT) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(k[CFG_IDX_W-1:0], LIM_MAX);
      write_reg(k[CFG_IDX_W-1:0], longint'($urandom_range(0, 65535)));
    end
    repeat (6) send_walk();
    wait_for_drain();
  endtask

  // Integral decay on both signs, and with a zero limit
  task automatic test_windup_decay();
    set_gains(0, 256, 0, 100, 200);
    repeat (12) send_error(90);
    repeat (12) send_error(-90);
    wait_for_drain();
    write_reg(REG_WINDUP_LIMIT, 0);
    repeat (6) send_error(37);
    repeat (4) send_error(-37);
    wait_for_drain();
  endtask

  // Drive the integral into both saturation limits; a minimal positive integral
  // gain keeps it visible while staying below the decay threshold
  task automatic test_integral_overflow();
    set_gains(-128, 1, 0, LIM_MAX, LIM_MAX);
    repeat (132) send_error(ERR_MAX);
    repeat (260) send_error(-ERR_MAX);
    wait_for_drain();
  endtask

  // Receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    set_gains(rand_gain(), rand_gain(), rand_gain(), 300, 2000);
    walk_err = 0;
    gaps_on = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (24) send_walk();
    gaps_on = 1'b1;
    wait_for_drain();
  endtask

  // Sender pauses until every result has come back, then resumes
  task automatic test_pause_resume();
    repeat (10) send_walk();
    wait_for_drain();
    repeat (10) send_walk();
    wait_for_drain();
  endtask

  // Random settings; mostly error walks near the band, some full-range noise
  task automatic test_random_phases();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit(400), rand_limit(3000));
      gaps_on = (ph % 3) != 2;
      walk_err = 0;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0)
          send_noise();
        else
          send_walk();
      end
      wait_for_drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst                       <= 1'b1;
    smp_bus.valid             <= 1'b0;
    smp_bus.measured_position <= '0;
    smp_bus.target_position   <= '0;
    cfg_bus.valid             <= 1'b0;
    cfg_bus.index             <= REG_PROP_GAIN;
    cfg_bus.data              <= '0;
    kp           = PROP_GAIN_RST;
    ki           = '0;
    kd           = '0;
    err_band     = ERROR_BAND_RST;
    windup_lim   = WINDUP_LIMIT_RST;
    last_err     = '0;
    integ        = '0;
    gaps_on      = 1'b1;
    hold_request = 0;
    walk_err     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_unknown_index();
    test_windup_decay();
    test_integral_overflow();
    test_backpressure();
    test_pause_resume();
    test_random_phases();

    wait_for_drain();
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
